// File: hw/rtl/sfd_pkg.sv
// Shared types, constants and the CRC helper of the stuffed frame deframer.
package sfd_pkg;

   localparam int MAX_PAYLOAD = 1024;

   // token queue between unstuffing front and frame parser (power of two depth)
   localparam int TOKQ_DEPTH = 4;
   localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);

   // result queue inside the frame parser
   localparam int OUTQ_DEPTH = 2;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHEST_TYPE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_VALUE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_VALUE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MASK   = 3'd4;

   localparam logic [10:0] RST_PAYLOAD_LIMIT = 11'd1024;
   localparam logic [7:0]  RST_HIGHEST_TYPE  = 8'hFF;
   localparam logic [7:0]  RST_FLAG_VALUE    = 8'h7E;
   localparam logic [7:0]  RST_ESCAPE_VALUE  = 8'h7D;
   localparam logic [7:0]  RST_ESCAPE_MASK   = 8'h20;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_FRAME   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_OVERSIZE  = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd2;
   localparam logic [2:0] STATUS_CRC       = 3'd3;
   localparam logic [2:0] STATUS_BAD_TYPE  = 3'd4;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [2:0] HEADER_BYTES = 3'd4;
   localparam logic [1:0] CHECK_BYTES  = 2'd2;

   typedef enum logic [1:0] {
      TOK_BODY,
      TOK_CLOSE,
      TOK_DBLESC
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic         esc;    // close token: an escape was still pending
      logic [7:0]   data;   // body token: unstuffed byte
   } token_type;

   typedef struct packed {
      logic [10:0] payload_limit;
      logic [7:0]  highest_type;
   } limits_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_data;
      logic [9:0]  payload_position;
      logic [7:0]  frame_seq;
      logic [7:0]  frame_kind_code;
      logic [10:0] frame_length;
      logic [2:0]  status;
   } result_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      int          k;
      c = crc ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/sfd_front.sv
// Front end: configuration registers, flag detection and byte unstuffing into tokens.
module sfd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic [7:0]                         req_line_byte,
   input  logic                               tok_full,
   output logic                               tok_push,
   output sfd_pkg::token_type                 tok,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]     csr_data,
   output sfd_pkg::limits_type                limits
);

   logic [10:0] payload_limit_ff;
   logic [7:0]  highest_type_ff;
   logic [7:0]  flag_value_ff;
   logic [7:0]  escape_value_ff;
   logic [7:0]  escape_mask_ff;

   logic        inside_ff, inside_in;
   logic        esc_ff, esc_in;
   logic        accept;
   logic        gen;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !tok_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_limit_ff <= sfd_pkg::RST_PAYLOAD_LIMIT;
         highest_type_ff  <= sfd_pkg::RST_HIGHEST_TYPE;
         flag_value_ff    <= sfd_pkg::RST_FLAG_VALUE;
         escape_value_ff  <= sfd_pkg::RST_ESCAPE_VALUE;
         escape_mask_ff   <= sfd_pkg::RST_ESCAPE_MASK;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sfd_pkg::CSR_PAYLOAD_LIMIT: payload_limit_ff <= csr_data[10:0];
            sfd_pkg::CSR_HIGHEST_TYPE:  highest_type_ff  <= csr_data[7:0];
            sfd_pkg::CSR_FLAG_VALUE:    flag_value_ff    <= csr_data[7:0];
            sfd_pkg::CSR_ESCAPE_VALUE:  escape_value_ff  <= csr_data[7:0];
            sfd_pkg::CSR_ESCAPE_MASK:   escape_mask_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign limits = {payload_limit_ff, highest_type_ff};

   always_comb begin
      inside_in = inside_ff;
      esc_in    = esc_ff;
      gen       = 1'b0;
      tok.kind  = sfd_pkg::TOK_BODY;
      tok.esc   = 1'b0;
      tok.data  = req_line_byte;
      if (accept) begin
         if (req_line_byte == flag_value_ff) begin
            // flag wins over escape when both match
            if (inside_ff) begin
               gen      = 1'b1;
               tok.kind = sfd_pkg::TOK_CLOSE;
               tok.esc  = esc_ff;
            end
            inside_in = 1'b1;
            esc_in    = 1'b0;
         end else if (!inside_ff) begin
            // drop bytes outside a frame
            gen = 1'b0;
         end else if (req_line_byte == escape_value_ff) begin
            if (esc_ff) begin
               gen      = 1'b1;
               tok.kind = sfd_pkg::TOK_DBLESC;
               esc_in   = 1'b0;
            end else begin
               esc_in = 1'b1;
            end
         end else begin
            gen = 1'b1;
            if (esc_ff) begin
               tok.data = req_line_byte ^ escape_mask_ff;
            end
            esc_in = 1'b0;
         end
      end
   end

   assign tok_push = gen;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         esc_ff    <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         esc_ff    <= esc_in;
      end
   end

endmodule

// File: hw/rtl/sfd_tokq.sv
// Short token queue between the unstuffing front and the frame parser.
module sfd_tokq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfd_pkg::token_type push_data,
   output logic               full,
   input  logic               pop,
   output sfd_pkg::token_type pop_data,
   output logic               empty
);

   localparam logic [sfd_pkg::TOKQ_AW-1:0] LAST_PTR = sfd_pkg::TOKQ_AW'(sfd_pkg::TOKQ_DEPTH - 1);
   localparam logic [sfd_pkg::TOKQ_AW:0]   DEPTH_CNT = (sfd_pkg::TOKQ_AW + 1)'(sfd_pkg::TOKQ_DEPTH);

   sfd_pkg::token_type              entry_ff [sfd_pkg::TOKQ_DEPTH];
   logic [sfd_pkg::TOKQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sfd_pkg::TOKQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sfd_pkg::TOKQ_AW:0]       count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/sfd_back.sv
// Frame parser: header, payload and check fields, CRC, closing status and result queue.
module sfd_back (
   input  logic                clock,
   input  logic                reset,
   input  sfd_pkg::limits_type limits,
   input  logic                tok_valid,
   input  sfd_pkg::token_type  tok,
   output logic                tok_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output sfd_pkg::result_type rsp
);

   localparam logic [sfd_pkg::OUTQ_AW-1:0] LAST_PTR  = sfd_pkg::OUTQ_AW'(sfd_pkg::OUTQ_DEPTH - 1);
   localparam logic [sfd_pkg::OUTQ_AW:0]   DEPTH_CNT = (sfd_pkg::OUTQ_AW + 1)'(sfd_pkg::OUTQ_DEPTH);
   localparam logic [15:0]                 MAX_LEN   = 16'(sfd_pkg::MAX_PAYLOAD);

   logic        discard_ff, discard_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [10:0] pay_cnt_ff, pay_cnt_in;
   logic [1:0]  chk_cnt_ff, chk_cnt_in;
   logic [15:0] rcv_crc_ff, rcv_crc_in;
   logic [15:0] crc_ff, crc_in;

   sfd_pkg::result_type             out_ff [sfd_pkg::OUTQ_DEPTH];
   logic [sfd_pkg::OUTQ_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sfd_pkg::OUTQ_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sfd_pkg::OUTQ_AW:0]       count_ff, count_in;

   logic                go;
   logic                emit;
   logic                do_pop;
   sfd_pkg::result_type res;
   logic [15:0]         full_len;
   logic [15:0]         crc_next;

   assign go       = tok_valid && (count_ff != DEPTH_CNT);
   assign tok_pop  = go;
   assign full_len = {tok.data, len_ff[7:0]};
   assign crc_next = sfd_pkg::crc_byte(crc_ff, tok.data);

   always_comb begin
      discard_in = discard_ff;
      hdr_cnt_in = hdr_cnt_ff;
      seq_in     = seq_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      pay_cnt_in = pay_cnt_ff;
      chk_cnt_in = chk_cnt_ff;
      rcv_crc_in = rcv_crc_ff;
      crc_in     = crc_ff;
      emit       = 1'b0;
      res        = '0;
      if (go) begin
         case (tok.kind)
            sfd_pkg::TOK_BODY: begin
               if (!discard_ff) begin
                  if (hdr_cnt_ff < sfd_pkg::HEADER_BYTES) begin
                     case (hdr_cnt_ff)
                        3'd0:    seq_in  = tok.data;
                        3'd1:    type_in = tok.data;
                        3'd2:    len_in  = {8'h00, tok.data};
                        default: len_in  = full_len;
                     endcase
                     crc_in     = crc_next;
                     hdr_cnt_in = hdr_cnt_ff + 1'b1;
                     if (hdr_cnt_ff == sfd_pkg::HEADER_BYTES - 1'b1 &&
                         (full_len > MAX_LEN || full_len > {5'b0, limits.payload_limit})) begin
                        discard_in = 1'b1;
                        emit       = 1'b1;
                        res.kind   = sfd_pkg::KIND_ERROR;
                        res.status = sfd_pkg::STATUS_OVERSIZE;
                     end
                  end else if ({5'b0, pay_cnt_ff} < len_ff) begin
                     crc_in                 = crc_next;
                     emit                   = 1'b1;
                     res.kind               = sfd_pkg::KIND_PAYLOAD;
                     res.payload_data       = tok.data;
                     res.payload_position   = pay_cnt_ff[9:0];
                     pay_cnt_in             = pay_cnt_ff + 1'b1;
                  end else if (chk_cnt_ff < sfd_pkg::CHECK_BYTES) begin
                     // check bytes arrive low byte first
                     if (chk_cnt_ff == 2'd0) begin
                        rcv_crc_in[7:0] = tok.data;
                     end else begin
                        rcv_crc_in[15:8] = tok.data;
                     end
                     chk_cnt_in = chk_cnt_ff + 1'b1;
                  end else begin
                     discard_in = 1'b1;
                     emit       = 1'b1;
                     res.kind   = sfd_pkg::KIND_ERROR;
                     res.status = sfd_pkg::STATUS_TRUNCATED;
                  end
               end
            end
            sfd_pkg::TOK_DBLESC: begin
               if (!discard_ff) begin
                  discard_in = 1'b1;
                  emit       = 1'b1;
                  res.kind   = sfd_pkg::KIND_ERROR;
                  res.status = sfd_pkg::STATUS_TRUNCATED;
               end
            end
            sfd_pkg::TOK_CLOSE: begin
               // empty flag pairs stay silent
               if (!discard_ff && (tok.esc || hdr_cnt_ff != 3'd0)) begin
                  emit = 1'b1;
                  if (tok.esc || hdr_cnt_ff != sfd_pkg::HEADER_BYTES ||
                      {5'b0, pay_cnt_ff} != len_ff || chk_cnt_ff != sfd_pkg::CHECK_BYTES) begin
                     res.kind   = sfd_pkg::KIND_ERROR;
                     res.status = sfd_pkg::STATUS_TRUNCATED;
                  end else if (crc_ff != rcv_crc_ff) begin
                     res.kind   = sfd_pkg::KIND_ERROR;
                     res.status = sfd_pkg::STATUS_CRC;
                  end else if (type_ff > limits.highest_type) begin
                     res.kind   = sfd_pkg::KIND_ERROR;
                     res.status = sfd_pkg::STATUS_BAD_TYPE;
                  end else begin
                     res.kind            = sfd_pkg::KIND_FRAME;
                     res.frame_seq       = seq_ff;
                     res.frame_kind_code = type_ff;
                     res.frame_length    = pay_cnt_ff;
                  end
               end
               discard_in = 1'b0;
               hdr_cnt_in = '0;
               seq_in     = '0;
               type_in    = '0;
               len_in     = '0;
               pay_cnt_in = '0;
               chk_cnt_in = '0;
               rcv_crc_in = '0;
               crc_in     = sfd_pkg::CRC_INIT;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff <= 1'b0;
         hdr_cnt_ff <= '0;
         seq_ff     <= '0;
         type_ff    <= '0;
         len_ff     <= '0;
         pay_cnt_ff <= '0;
         chk_cnt_ff <= '0;
         rcv_crc_ff <= '0;
         crc_ff     <= sfd_pkg::CRC_INIT;
      end else begin
         discard_ff <= discard_in;
         hdr_cnt_ff <= hdr_cnt_in;
         seq_ff     <= seq_in;
         type_ff    <= type_in;
         len_ff     <= len_in;
         pay_cnt_ff <= pay_cnt_in;
         chk_cnt_ff <= chk_cnt_in;
         rcv_crc_ff <= rcv_crc_in;
         crc_ff     <= crc_in;
      end
   end

   // result queue
   assign rsp_empty = (count_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign rsp       = out_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (emit) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (emit && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !emit) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/stuffed_frame_deframer_unit.sv
// Byte-stuffed frame deframer with CRC-16/CCITT-FALSE check, top level.
//
// Request channel: one raw line byte per request, taken when req_push is high
// and req_full is low. Flag bytes open and close frames, escape bytes unstuff
// the next byte; bytes outside a frame are dropped.
// Response channel: the oldest result sits on the rsp_ ports while rsp_empty is
// low and leaves when rsp_pop is high. A result is a payload byte (emitted as it
// arrives; discard it unless the closing result is a good frame), a good frame
// with its header, or an error status.
// Configuration: csr_valid/csr_ready write port, always ready; write only while
// no request is in flight.
// A request's token is registered in the token queue, and its result in the result
// queue, before the result shows on the rsp_ ports.
// Throughput: one request per cycle while req_full is low, set by the single-byte
// CRC step of the frame parser. A four-entry token queue decouples unstuffing
// from parsing, and a two-entry result queue lets the parser run on while a
// result waits. When the receiver stalls, both queues fill and req_full rises.
// Reset: clears both queues, drops any open frame and restores the default
// delimiter, escape, mask and limits.
module stuffed_frame_deframer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_line_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_payload_data,
   output logic [9:0]                     rsp_payload_position,
   output logic [7:0]                     rsp_frame_seq,
   output logic [7:0]                     rsp_frame_kind_code,
   output logic [10:0]                    rsp_frame_length,
   output logic [2:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0] csr_data
);

   sfd_pkg::token_type  front_tok;
   sfd_pkg::token_type  head_tok;
   sfd_pkg::limits_type limits;
   sfd_pkg::result_type rsp;
   logic                front_push;
   logic                tokq_full;
   logic                tokq_empty;
   logic                tokq_pop;

   assign req_full = tokq_full;

   sfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_line_byte (req_line_byte),
      .tok_full      (tokq_full),
      .tok_push      (front_push),
      .tok           (front_tok),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .limits        (limits)
   );

   sfd_tokq u_tokq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_tok),
      .full      (tokq_full),
      .pop       (tokq_pop),
      .pop_data  (head_tok),
      .empty     (tokq_empty)
   );

   sfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .limits    (limits),
      .tok_valid (!tokq_empty),
      .tok       (head_tok),
      .tok_pop   (tokq_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_kind             = rsp.kind;
   assign rsp_payload_data     = rsp.payload_data;
   assign rsp_payload_position = rsp.payload_position;
   assign rsp_frame_seq        = rsp.frame_seq;
   assign rsp_frame_kind_code  = rsp.frame_kind_code;
   assign rsp_frame_length     = rsp.frame_length;
   assign rsp_status           = rsp.status;

endmodule

// File: hw/rtl/sfd_checker.sv
// Port-level checker of the deframer, bound to the top level.
module sfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_payload_data,
   input logic [7:0]  rsp_frame_seq,
   input logic [10:0] rsp_frame_length,
   input logic [2:0]  rsp_status
);

   a_reset_clears: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_kind == sfd_pkg::KIND_PAYLOAD || rsp_kind == sfd_pkg::KIND_FRAME ||
                      rsp_kind == sfd_pkg::KIND_ERROR))
      else $error("illegal result kind");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == sfd_pkg::KIND_PAYLOAD) |->
         (rsp_status == sfd_pkg::STATUS_OK && rsp_frame_seq == 8'd0 && rsp_frame_length == 11'd0))
      else $error("payload result carries frame fields");

   a_error_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == sfd_pkg::KIND_ERROR) |->
         (rsp_payload_data == 8'd0 &&
          (rsp_status == sfd_pkg::STATUS_OVERSIZE || rsp_status == sfd_pkg::STATUS_TRUNCATED ||
           rsp_status == sfd_pkg::STATUS_CRC || rsp_status == sfd_pkg::STATUS_BAD_TYPE)))
      else $error("error result with bad status");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == sfd_pkg::KIND_FRAME) |->
         (rsp_status == sfd_pkg::STATUS_OK &&
          rsp_frame_length <= 11'(sfd_pkg::MAX_PAYLOAD)))
      else $error("frame result out of range");

endmodule

bind stuffed_frame_deframer_unit sfd_checker u_sfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_kind         (rsp_kind),
   .rsp_payload_data (rsp_payload_data),
   .rsp_frame_seq    (rsp_frame_seq),
   .rsp_frame_length (rsp_frame_length),
   .rsp_status       (rsp_status)
);
